// ===== hdl/tcq_pkg.sv =====
// Shared types and constants for the two-class oldest-first queue.
`default_nettype none

package tcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int STAMP_BITS_DEF  = 16;

    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TAG_W       = 32;
    localparam int OUT_STAMP_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ     = 2'd0,
        KIND_DEQ_ANY = 2'd1,
        KIND_DEQ_C0  = 2'd2,
        KIND_DEQ_C1  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

`default_nettype wire

// ===== hdl/tcq_cmd_if.sv =====
// Command channel: valid/ready handshake with the command item.
`default_nettype none

interface tcq_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tcq_pkg::KIND_W-1:0] kind;
    logic                       item_class;
    logic [tcq_pkg::TAG_W-1:0]  payload_tag;

    modport source (output valid, output kind, output item_class, output payload_tag,
                    input ready);
    modport sink   (input valid, input kind, input item_class, input payload_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/tcq_res_if.sv =====
// Result channel: valid/ready handshake with the result item.
`default_nettype none

interface tcq_res_if;
    logic                            valid;
    logic                            ready;
    logic [tcq_pkg::STATUS_W-1:0]    status;
    logic                            out_class;
    logic [tcq_pkg::TAG_W-1:0]       out_tag;
    logic [tcq_pkg::OUT_STAMP_W-1:0] out_stamp;

    modport source (output valid, output status, output out_class, output out_tag,
                    output out_stamp, input ready);
    modport sink   (input valid, input status, input out_class, input out_tag,
                    input out_stamp, output ready);
endinterface

`default_nettype wire

// ===== hdl/two_class_oldest_first_queue_core.sv =====
// A command passes the input register and then the result register on its way to the result port.
// Throughput: one command per cycle while results are taken; each FIFO's head entry is read ahead from its memory.
// Input ready drops only when the result register is full and not being taken.
// Reset: pointers, counts, arrival counter and valid flags clear; stores are not cleared.
// Top level of the two-class oldest-first queue.
`default_nettype none

module two_class_oldest_first_queue_core #(
    parameter int QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int STAMP_BITS  = tcq_pkg::STAMP_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcq_cmd_if.sink    i_cmd,
    tcq_res_if.source  o_res
);

    localparam int OSW = tcq_pkg::OUT_STAMP_W;

    // input register
    logic                        r_in_vld;
    tcq_pkg::t_kind              r_kind;
    logic                        r_cls;
    logic [tcq_pkg::TAG_W-1:0]   r_tag;

    logic [STAMP_BITS-1:0]       r_arrival;

    // result register
    logic                        r_out_vld;
    tcq_pkg::t_status            r_status;
    logic                        r_out_cls;
    logic [tcq_pkg::TAG_W-1:0]   r_out_tag;
    logic [OSW-1:0]              r_out_stamp;

    tcq_pkg::t_status            n_status;
    logic                        n_cls;
    logic [tcq_pkg::TAG_W-1:0]   n_tag;
    logic [STAMP_BITS-1:0]       n_stamp;

    logic                        adv;
    logic                        have;
    logic                        pick;
    logic                        enq_ok;
    logic                        older1;
    logic [STAMP_BITS-1:0]       stamp_diff;

    tcq_pkg::t_fifo_ctl          ctl0;
    tcq_pkg::t_fifo_ctl          ctl1;
    tcq_pkg::t_fifo_sts          sts0;
    tcq_pkg::t_fifo_sts          sts1;
    logic [tcq_pkg::TAG_W-1:0]   hd_tag0;
    logic [tcq_pkg::TAG_W-1:0]   hd_tag1;
    logic [STAMP_BITS-1:0]       hd_stamp0;
    logic [STAMP_BITS-1:0]       hd_stamp1;

    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_kind <= tcq_pkg::t_kind'(i_cmd.kind);
            r_cls  <= i_cmd.item_class;
            r_tag  <= i_cmd.payload_tag;
        end
    end

    // class 1 head is older when (s1 - s0) has its top bit set
    assign stamp_diff = hd_stamp1 - hd_stamp0;
    assign older1     = stamp_diff[STAMP_BITS-1];

    always_comb begin
        have   = 1'b0;
        pick   = 1'b0;
        enq_ok = 1'b0;
        unique case (r_kind)
            tcq_pkg::KIND_ENQ: begin
                enq_ok = r_cls ? !sts1.full : !sts0.full;
            end
            tcq_pkg::KIND_DEQ_ANY: begin
                have = !sts0.empty || !sts1.empty;
                pick = sts0.empty ? 1'b1 : (sts1.empty ? 1'b0 : older1);
            end
            tcq_pkg::KIND_DEQ_C0: begin
                have = !sts0.empty;
                pick = 1'b0;
            end
            tcq_pkg::KIND_DEQ_C1: begin
                have = !sts1.empty;
                pick = 1'b1;
            end
            default: begin
                have = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_status = tcq_pkg::ST_EMPTY;
        n_cls    = 1'b0;
        n_tag    = '0;
        n_stamp  = '0;
        if (r_kind == tcq_pkg::KIND_ENQ) begin
            n_cls = r_cls;
            if (enq_ok) begin
                n_status = tcq_pkg::ST_ENQ;
                n_stamp  = r_arrival;
            end else begin
                n_status = tcq_pkg::ST_FULL;
            end
        end else if (have) begin
            n_status = tcq_pkg::ST_DEQ;
            n_cls    = pick;
            n_tag    = pick ? hd_tag1 : hd_tag0;
            n_stamp  = pick ? hd_stamp1 : hd_stamp0;
        end
    end

    assign ctl0.push = adv && enq_ok && !r_cls;
    assign ctl1.push = adv && enq_ok && r_cls;
    assign ctl0.pop  = adv && have && !pick;
    assign ctl1.pop  = adv && have && pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival <= '0;
        end else if (ctl0.push || ctl1.push) begin
            r_arrival <= r_arrival + STAMP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status    <= n_status;
            r_out_cls   <= n_cls;
            r_out_tag   <= n_tag;
            r_out_stamp <= OSW'(n_stamp);
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.status    = r_status;
    assign o_res.out_class = r_out_cls;
    assign o_res.out_tag   = r_out_tag;
    assign o_res.out_stamp = r_out_stamp;

    tcq_fifo #(
        .DEPTH      (QUEUE_DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_fifo0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl0),
        .i_wr_tag   (r_tag),
        .i_wr_stamp (r_arrival),
        .o_sts      (sts0),
        .o_hd_tag   (hd_tag0),
        .o_hd_stamp (hd_stamp0)
    );

    tcq_fifo #(
        .DEPTH      (QUEUE_DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_fifo1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl1),
        .i_wr_tag   (r_tag),
        .i_wr_stamp (r_arrival),
        .o_sts      (sts1),
        .o_hd_tag   (hd_tag1),
        .o_hd_stamp (hd_stamp1)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((ctl0.push && sts0.full) || (ctl1.push && sts1.full)))
        else $error("push into a full class FIFO");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((ctl0.pop && sts0.empty) || (ctl1.pop && sts1.empty)))
        else $error("pop from an empty class FIFO");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl0.push, ctl0.pop, ctl1.push, ctl1.pop}))
        else $error("more than one FIFO operation in a cycle");

    a_arrival_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_arrival != $past(r_arrival)))
            |-> $past(ctl0.push || ctl1.push))
        else $error("arrival counter moved without a stored item");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_cmd.ready)
        else $error("input stalled while result register is free");
`endif

endmodule

`default_nettype wire

// ===== hdl/tcq_fifo.sv =====
// One class FIFO: entry memory, pointers, count and a registered head entry.
`default_nettype none

module tcq_fifo #(
    parameter int DEPTH      = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int STAMP_BITS = tcq_pkg::STAMP_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tcq_pkg::t_fifo_ctl          i_ctl,
    input  wire logic [tcq_pkg::TAG_W-1:0]   i_wr_tag,
    input  wire logic [STAMP_BITS-1:0]       i_wr_stamp,
    output tcq_pkg::t_fifo_sts               o_sts,
    output logic [tcq_pkg::TAG_W-1:0]        o_hd_tag,
    output logic [STAMP_BITS-1:0]            o_hd_stamp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = tcq_pkg::TAG_W + STAMP_BITS;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_head;
    logic [ENT_W-1:0] wr_ent;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        return (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
    endfunction

    assign wr_ent = {i_wr_tag, i_wr_stamp};
    assign n_head = i_ctl.pop ? next_ptr(r_head) : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head <= n_head;
            if (i_ctl.push) begin
                r_tail <= next_ptr(r_tail);
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Read the next head each cycle; forward a write that lands on it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= wr_ent;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_rd <= wr_ent;
        end else begin
            r_rd <= mem[n_head];
        end
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == FULL_CNT);
    assign o_hd_tag    = r_rd[ENT_W-1:STAMP_BITS];
    assign o_hd_stamp  = r_rd[STAMP_BITS-1:0];

endmodule

`default_nettype wire

// ===== bench/tb_two_class_oldest_first_queue_core.sv =====
// Testbench for the two-class oldest-first queue: directed and random commands vs a queue model.
module tb_two_class_oldest_first_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = tcq_pkg::QUEUE_DEPTH_DEF;
    localparam int STAMP_W     = tcq_pkg::STAMP_BITS_DEF;
    localparam int TAG_W       = tcq_pkg::TAG_W;
    localparam int OUT_STAMP_W = tcq_pkg::OUT_STAMP_W;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

    typedef struct {
        tcq_pkg::t_status       status;
        logic                   cls;
        logic [TAG_W-1:0]       tag;
        logic [OUT_STAMP_W-1:0] stamp;
    } t_response;

    logic i_clk;
    logic i_rst_n;

    tcq_cmd_if cmd_if ();
    tcq_res_if res_if ();

    two_class_oldest_first_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Model state: one FIFO per class and the running arrival stamp.
    t_slot              class0_fifo[$];
    t_slot              class1_fifo[$];
    logic [STAMP_W-1:0] arrival_stamp = '0;

    t_response due_responses[$];
    int        err_count     = 0;
    bit        send_gaps     = 1'b0;
    bit        rx_random     = 1'b0;
    int        rx_hold_cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_response compute_response(input tcq_pkg::t_kind kind, input logic cls,
                                                   input logic [TAG_W-1:0] tag);
        t_response          r;
        t_slot              s;
        logic               have;
        logic               pick;
        logic [STAMP_W-1:0] d;
        r = '{status: tcq_pkg::ST_EMPTY, cls: 1'b0, tag: '0, stamp: '0};
        have = 1'b0;
        pick = 1'b0;
        if (kind == tcq_pkg::KIND_ENQ) begin
            r.cls = cls;
            if ((cls ? class1_fifo.size() : class0_fifo.size()) >= DEPTH) begin
                r.status = tcq_pkg::ST_FULL;
            end else begin
                s.tag   = tag;
                s.stamp = arrival_stamp;
                if (cls) class1_fifo = {class1_fifo, s};
                else class0_fifo = {class0_fifo, s};
                arrival_stamp = arrival_stamp + 1'b1;
                r.status = tcq_pkg::ST_ENQ;
                r.stamp  = s.stamp;
            end
        end else begin
            if (kind == tcq_pkg::KIND_DEQ_C0) begin
                have = class0_fifo.size() != 0;
                pick = 1'b0;
            end else if (kind == tcq_pkg::KIND_DEQ_C1) begin
                have = class1_fifo.size() != 0;
                pick = 1'b1;
            end else if (class0_fifo.size() == 0 && class1_fifo.size() == 0) begin
                have = 1'b0;
            end else if (class1_fifo.size() == 0) begin
                have = 1'b1;
                pick = 1'b0;
            end else if (class0_fifo.size() == 0) begin
                have = 1'b1;
                pick = 1'b1;
            end else begin
                // class 1 wins only when strictly older, modulo the stamp width
                d    = class1_fifo[0].stamp - class0_fifo[0].stamp;
                have = 1'b1;
                pick = d[STAMP_W-1];
            end
            if (have) begin
                if (pick) begin
                    s = class1_fifo[0];
                    class1_fifo.delete(0);
                end else begin
                    s = class0_fifo[0];
                    class0_fifo.delete(0);
                end
                r.status = tcq_pkg::ST_DEQ;
                r.cls    = pick;
                r.tag    = s.tag;
                r.stamp  = s.stamp;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!send_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with valid held.
    task automatic issue_cmd(input tcq_pkg::t_kind kind, input logic cls,
                             input logic [TAG_W-1:0] tag);
        int        gap;
        t_response rsp;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= kind;
        cmd_if.item_class  <= cls;
        cmd_if.payload_tag <= tag;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        rsp = compute_response(kind, cls, tag);
        due_responses = {due_responses, rsp};
        @(negedge i_clk);
    endtask

    // Hold input, let every outstanding result arrive, then cover the pipeline latency.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (due_responses.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_responses.size() == 0) begin
                $error("result with no command outstanding");
                err_count++;
            end else begin
                e = due_responses[0];
                due_responses.delete(0);
                if (res_if.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, res_if.status);
                    err_count++;
                end
                if (res_if.out_class !== e.cls) begin
                    $error("out_class: expected %0d, actual %0d", e.cls, res_if.out_class);
                    err_count++;
                end
                if (res_if.out_tag !== e.tag) begin
                    $error("out_tag: expected %h, actual %h", e.tag, res_if.out_tag);
                    err_count++;
                end
                if (res_if.out_stamp !== e.stamp) begin
                    $error("out_stamp: expected %0d, actual %0d", e.stamp, res_if.out_stamp);
                    err_count++;
                end
            end
        end
    end

    // Result side: free, random stalls, or a long hold requested by a test.
    initial begin
        int stall_left;
        int n;
        int r;
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
                res_if.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!rx_random) begin
                res_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(6, 25);
                end
            end
        end
    end

    task automatic test_empty_dequeues();
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b1, 32'hFFFF_FFFF);
        issue_cmd(tcq_pkg::KIND_DEQ_C0, 1'b0, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_C1, 1'b1, $urandom);
    endtask

    task automatic test_order_and_extremes();
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b0, 32'h0000_0000);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b1, 32'hFFFF_FFFF);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b1, 32'h5555_5555);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b0, 32'hAAAA_AAAA);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b1, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b0, '1);
        issue_cmd(tcq_pkg::KIND_DEQ_C0, 1'b1, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b0, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b1, '1);
        // one class empty while the other holds items
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b0, $urandom);
        issue_cmd(tcq_pkg::KIND_DEQ_C1, 1'b0, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b0, '0);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b1, $urandom);
        issue_cmd(tcq_pkg::KIND_DEQ_C0, 1'b1, '0);
        issue_cmd(tcq_pkg::KIND_DEQ_ANY, 1'b1, '0);
    endtask

    // Hold the result side long enough that the block stalls, filling both classes.
    task automatic test_fill_under_backpressure();
        int i;
        send_gaps      = 1'b0;
        rx_random      = 1'b0;
        rx_hold_cycles = 80;
        for (i = 0; i < 2 * DEPTH; i++) issue_cmd(tcq_pkg::KIND_ENQ, i[0], $urandom);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b0, $urandom);
        issue_cmd(tcq_pkg::KIND_ENQ, 1'b1, $urandom);
        wait_drained();
        send_gaps = 1'b1;
        rx_random = 1'b1;
        for (i = 0; i < 2 * DEPTH + 1; i++) begin
            issue_cmd(tcq_pkg::KIND_DEQ_ANY, $urandom_range(0, 1), $urandom);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int             sent;
        int             r;
        int             cnt;
        int             seg;
        logic           cls;
        tcq_pkg::t_kind kind;
        sent = 0;
        while (sent < n_items) begin
            seg       = sent / 80;
            send_gaps = (seg % 3) != 1;
            rx_random = (seg % 3) != 2;
            r   = $urandom_range(0, 99);
            cls = $urandom_range(0, 1);
            if (r < 3) begin
                // push one class past full
                cnt = DEPTH + 1 - (cls ? class1_fifo.size() : class0_fifo.size());
                repeat (cnt) issue_cmd(tcq_pkg::KIND_ENQ, cls, $urandom);
                sent += cnt;
            end else if (r < 6) begin
                cnt = class0_fifo.size() + class1_fifo.size() + 1;
                repeat (cnt) issue_cmd(tcq_pkg::KIND_DEQ_ANY, $urandom_range(0, 1), $urandom);
                sent += cnt;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 48) kind = tcq_pkg::KIND_ENQ;
                else if (r < 74) kind = tcq_pkg::KIND_DEQ_ANY;
                else if (r < 87) kind = tcq_pkg::KIND_DEQ_C0;
                else kind = tcq_pkg::KIND_DEQ_C1;
                issue_cmd(kind, cls, ($urandom_range(0, 19) == 0) ? {TAG_W{cls}} : $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        cmd_if.valid       = 1'b0;
        cmd_if.kind        = tcq_pkg::KIND_ENQ;
        cmd_if.item_class  = 1'b0;
        cmd_if.payload_tag = '0;
        i_rst_n            = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_dequeues();
        test_order_and_extremes();
        wait_drained();
        test_fill_under_backpressure();
        wait_drained();
        test_random_traffic(320);
        wait_drained();

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tcq_pkg.sv
hdl/tcq_cmd_if.sv
hdl/tcq_res_if.sv
hdl/tcq_fifo.sv
hdl/two_class_oldest_first_queue_core.sv
bench/tb_two_class_oldest_first_queue_core.sv
